// ===== hw/rtl/vector_unpack_mask_row_col_top_assert.svh =====
// ----------------------------------------------------------------------------
// vector unpack assertion macros
// shared concurrent checks, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef VECTOR_UNPACK_MASK_ROW_COL_TOP_ASSERT_SVH
`define VECTOR_UNPACK_MASK_ROW_COL_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define VUMRC_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vumrc same-cycle check failed");

// antecedent implies consequent in the next cycle
`define VUMRC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vumrc next-cycle check failed");

`else

`define VUMRC_ASSERT_IMPLY(label, ante, cons)
`define VUMRC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/vumrc_pkg.sv =====
// ----------------------------------------------------------------------------
// vumrc_pkg
// types, codes and helpers shared by the vector unpack block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vumrc_pkg;

	// configuration register indexes
	typedef logic [2:0] cfg_index_t;
	localparam cfg_index_t CFG_UNPACK_CONTROL = 3'd0;
	localparam cfg_index_t CFG_WRITE_MASK     = 3'd1;
	localparam cfg_index_t CFG_COLUMN0        = 3'd2;
	localparam cfg_index_t CFG_COLUMN1        = 3'd3;
	localparam cfg_index_t CFG_COLUMN2        = 3'd4;
	localparam cfg_index_t CFG_COLUMN3        = 3'd5;

	// element count codes
	localparam logic [1:0] VN_S  = 2'd0;
	localparam logic [1:0] VN_V2 = 2'd1;
	localparam logic [1:0] VN_V3 = 2'd2;
	localparam logic [1:0] VN_V4 = 2'd3;

	// element size codes
	localparam logic [1:0] VL_32   = 2'd0;
	localparam logic [1:0] VL_16   = 2'd1;
	localparam logic [1:0] VL_8    = 2'd2;
	localparam logic [1:0] VL_5551 = 2'd3;

	localparam logic [3:0] FMT_COLOUR = 4'hF;

	// write mask codes
	localparam logic [1:0] SEL_DATA    = 2'd0;
	localparam logic [1:0] SEL_ROW     = 2'd1;
	localparam logic [1:0] SEL_COLUMN  = 2'd2;
	localparam logic [1:0] SEL_PROTECT = 2'd3;

	// row modes
	localparam logic [1:0] ROW_MODE_ADD = 2'd1;
	localparam logic [1:0] ROW_MODE_ACC = 2'd2;

	// opcodes
	localparam logic OP_UNPACK   = 1'b0;
	localparam logic OP_LOAD_ROW = 1'b1;

	// 5551 colour fields
	localparam logic [15:0] COLOUR_R_MASK = 16'h001f;
	localparam logic [15:0] COLOUR_G_MASK = 16'h03e0;
	localparam logic [15:0] COLOUR_B_MASK = 16'h7c00;
	localparam logic [15:0] COLOUR_A_MASK = 16'h8000;

	typedef struct packed {
		logic [1:0] row_mode;
		logic       mask_en;
		logic       uns;
		logic [1:0] vn;
		logic [1:0] vl;
	} ctrl_t;

	typedef struct packed {
		logic        opcode;
		logic [1:0]  cycle_index;
		logic [2:0]  remaining;
		logic [1:0]  row_select;
		logic [31:0] word_a;
		logic [31:0] word_b;
		logic [31:0] word_c;
		logic [31:0] word_d;
	} in_item_t;

	typedef struct packed {
		logic [31:0] lane_x;
		logic [31:0] lane_y;
		logic [31:0] lane_z;
		logic [31:0] lane_w;
		logic [3:0]  lane_written;
		logic [1:0]  next_offset;
	} out_item_t;

	// per-lane decision handed from the unpacker to the row stage
	typedef struct packed {
		logic [3:0]        visit;
		logic [3:0][1:0]   sel;
		logic [3:0][31:0]  data;
		logic              colour;
		logic [1:0]        next_offset;
	} lane_plan_t;

	// element k of the packed words, sign or zero extended
	function automatic logic [31:0] element(input logic [3:0][31:0] w, input logic [1:0] vl,
			input logic uns, input logic [1:0] k);
		logic [15:0] h;
		logic [7:0]  b;
		logic [31:0] r;
		h = k[0] ? w[{1'b0, k[1]}][31:16] : w[{1'b0, k[1]}][15:0];
		b = w[0][{k, 3'b000} +: 8];
		unique case (vl)
			VL_32: begin
				r = w[k];
			end
			VL_16: begin
				r = {{16{h[15] & ~uns}}, h};
			end
			default: begin
				r = {{24{b[7] & ~uns}}, b};
			end
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vector_unpack_mask_row_col_top.sv =====
// ----------------------------------------------------------------------------
// vector_unpack_mask_row_col_top
// unpacks one packed item per clock while the result is taken, into lanes X, Y, Z, W with write mask
//
// channels: cfg (index, data) writes the control, mask and column registers
// and is always ready; the user must write it only while no item is in
// flight (not enforced by the block). item carries the packed data or a row
// register load; result carries the four lane values, the written bits and
// the lane offset after the item.
// pipeline: an accepted item is held in the input register and its result
// is then loaded into the output register, which drives result.
// throughput: one item per clock while not stalled; the lane offset and
// row accumulators are updated as an item leaves the input register, so
// the next item sees them.
// stall: while result_ready is low the result holds, the input register
// still fills, and item_ready drops only when both registers are full.
// reset: clears the valid flags, the configuration registers, the lane
// offset and the row registers to 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "vector_unpack_mask_row_col_top_assert.svh"

module vector_unpack_mask_row_col_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  vumrc_pkg::cfg_index_t cfg_index,
	input  logic [31:0]           cfg_data,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  vumrc_pkg::in_item_t   item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output vumrc_pkg::out_item_t  result
);

	vumrc_pkg::ctrl_t      ctrl_q;
	logic [31:0]           write_mask_q;
	logic [3:0][31:0]      column_q;
	logic [1:0]            lane_offset_q;

	vumrc_pkg::in_item_t   item_s1;
	logic                  item_valid_s1;
	vumrc_pkg::out_item_t  result_s2;
	logic                  result_valid_s2;

	vumrc_pkg::lane_plan_t plan;
	logic [3:0][31:0]      lanes;
	logic [3:0]            written;
	logic                  advance;

	assign advance    = item_valid_s1 && (!result_valid_s2 || result_ready);
	assign item_ready = !item_valid_s1 || advance;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q       <= '0;
			write_mask_q <= '0;
			column_q     <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				vumrc_pkg::CFG_UNPACK_CONTROL: ctrl_q       <= cfg_data[7:0];
				vumrc_pkg::CFG_WRITE_MASK:     write_mask_q <= cfg_data;
				vumrc_pkg::CFG_COLUMN0:        column_q[0]  <= cfg_data;
				vumrc_pkg::CFG_COLUMN1:        column_q[1]  <= cfg_data;
				vumrc_pkg::CFG_COLUMN2:        column_q[2]  <= cfg_data;
				vumrc_pkg::CFG_COLUMN3:        column_q[3]  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_ready) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	vumrc_unpack u_unpack (
		.item       (item_s1),
		.ctrl       (ctrl_q),
		.write_mask (write_mask_q),
		.offset     (lane_offset_q),
		.plan       (plan)
	);

	vumrc_rows u_rows (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.load       (item_s1.opcode == vumrc_pkg::OP_LOAD_ROW),
		.row_select (item_s1.row_select),
		.load_data  (item_s1.word_a),
		.row_mode   (ctrl_q.row_mode),
		.column     (column_q[item_s1.cycle_index]),
		.plan       (plan),
		.lanes      (lanes),
		.written    (written)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_offset_q   <= 2'd0;
			result_valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				lane_offset_q <= plan.next_offset;
			end
			if (advance) begin
				result_valid_s2 <= 1'b1;
			end else if (result_ready) begin
				result_valid_s2 <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.lane_x       <= lanes[0];
			result_s2.lane_y       <= lanes[1];
			result_s2.lane_z       <= lanes[2];
			result_s2.lane_w       <= lanes[3];
			result_s2.lane_written <= written;
			result_s2.next_offset  <= plan.next_offset;
		end
	end

	assign result_valid = result_valid_s2;
	assign result       = result_s2;

	`VUMRC_ASSERT_IMPLY(a_ready_only_full, !item_ready, (item_valid_s1 && result_valid_s2 && !result_ready))
	`VUMRC_ASSERT_NEXT(a_s1_holds, (item_valid_s1 && !advance), (item_valid_s1 && $stable(item_s1)))
	`VUMRC_ASSERT_NEXT(a_load_keeps_offset, (advance && item_s1.opcode == vumrc_pkg::OP_LOAD_ROW), (result_s2.lane_written == 4'd0 && $stable(lane_offset_q)))
	`VUMRC_ASSERT_IMPLY(a_unwritten_zero, result_valid_s2, ((result_s2.lane_written[0] || result_s2.lane_x == 32'd0) && (result_s2.lane_written[3] || result_s2.lane_w == 32'd0)))

endmodule

`default_nettype wire

// ===== hw/rtl/vumrc_unpack.sv =====
// ----------------------------------------------------------------------------
// vumrc_unpack
// picks the lanes an item visits and the element each visited lane receives
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vumrc_unpack (
	input  vumrc_pkg::in_item_t   item,
	input  vumrc_pkg::ctrl_t      ctrl,
	input  logic [31:0]           write_mask,
	input  logic [1:0]            offset,
	output vumrc_pkg::lane_plan_t plan
);

	always_comb begin
		logic [3:0][31:0] w;
		logic [2:0]       size_left;
		logic             active;
		logic [1:0]       p;
		logic [1:0]       lane;
		logic             sized;
		logic             undefined;
		logic [2:0]       count;
		logic [7:0]       mask_byte;

		w         = {item.word_d, item.word_c, item.word_b, item.word_a};
		undefined = (ctrl.vl == vumrc_pkg::VL_5551) && (ctrl.vn != vumrc_pkg::VN_V4);
		mask_byte = write_mask[{item.cycle_index, 3'b000} +: 8];
		size_left = item.remaining;
		active    = (item.opcode == vumrc_pkg::OP_UNPACK) && !undefined;
		p         = 2'd0;
		count     = 3'd0;
		plan      = '0;
		plan.colour = ({ctrl.vn, ctrl.vl} == vumrc_pkg::FMT_COLOUR);

		for (int j = 0; j < 4; j++) begin
			lane  = 2'(j);
			// upper lanes of V2 and W of V3 ignore the remaining count
			sized = !(ctrl.vn == vumrc_pkg::VN_V2 && lane[1])
				&& !(ctrl.vn == vumrc_pkg::VN_V3 && lane == 2'd3);

			if (plan.colour) begin
				unique case (lane)
					2'd0: plan.data[j] = 32'(item.word_a[15:0] & vumrc_pkg::COLOUR_R_MASK) << 3;
					2'd1: plan.data[j] = 32'(item.word_a[15:0] & vumrc_pkg::COLOUR_G_MASK) >> 2;
					2'd2: plan.data[j] = 32'(item.word_a[15:0] & vumrc_pkg::COLOUR_B_MASK) >> 7;
					default: plan.data[j] = 32'(item.word_a[15:0] & vumrc_pkg::COLOUR_A_MASK) >> 8;
				endcase
			end else if (ctrl.vn == vumrc_pkg::VN_S) begin
				plan.data[j] = vumrc_pkg::element(w, ctrl.vl, ctrl.uns, 2'd0);
			end else if (ctrl.vn == vumrc_pkg::VN_V2 && lane == 2'd3
					&& ctrl.vl == vumrc_pkg::VL_32) begin
				plan.data[j] = 32'd0;
			end else begin
				plan.data[j] = vumrc_pkg::element(w, ctrl.vl, ctrl.uns, p);
			end

			plan.sel[j] = ctrl.mask_en ? mask_byte[2*j +: 2] : vumrc_pkg::SEL_DATA;

			if (active && lane >= offset) begin
				if (sized && size_left == 3'd0) begin
					active = 1'b0;
				end else begin
					plan.visit[j] = 1'b1;
					count = count + 3'd1;
					if (sized) begin
						size_left = size_left - 3'd1;
					end
					// V2 steps the element pointer back after Y
					if (!plan.colour && ctrl.vn != vumrc_pkg::VN_S) begin
						p = (ctrl.vn == vumrc_pkg::VN_V2 && lane == 2'd1) ? p - 2'd1 : p + 2'd1;
					end
				end
			end
		end

		// visiting all four lanes brings the offset back where it was
		plan.next_offset = offset + count[1:0];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/vumrc_rows.sv =====
// ----------------------------------------------------------------------------
// vumrc_rows
// row registers and the per-lane data, row and column selection
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vumrc_rows (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  load,
	input  logic [1:0]            row_select,
	input  logic [31:0]           load_data,
	input  logic [1:0]            row_mode,
	input  logic [31:0]           column,
	input  vumrc_pkg::lane_plan_t plan,
	output logic [3:0][31:0]      lanes,
	output logic [3:0]            written
);

	logic [3:0][31:0] row_q;
	logic [3:0][31:0] sum;
	logic [3:0]       acc_en;

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			sum[j]     = row_q[j] + plan.data[j];
			acc_en[j]  = plan.visit[j] && plan.sel[j] == vumrc_pkg::SEL_DATA && !plan.colour
				&& row_mode == vumrc_pkg::ROW_MODE_ACC;
			lanes[j]   = 32'd0;
			written[j] = 1'b0;
			if (plan.visit[j]) begin
				unique case (plan.sel[j])
					vumrc_pkg::SEL_DATA: begin
						written[j] = 1'b1;
						priority if (plan.colour) begin
							lanes[j] = plan.data[j];
						end else if (row_mode == vumrc_pkg::ROW_MODE_ADD
								|| row_mode == vumrc_pkg::ROW_MODE_ACC) begin
							lanes[j] = sum[j];
						end else begin
							lanes[j] = plan.data[j];
						end
					end
					vumrc_pkg::SEL_ROW: begin
						written[j] = 1'b1;
						lanes[j]   = row_q[j];
					end
					vumrc_pkg::SEL_COLUMN: begin
						written[j] = 1'b1;
						lanes[j]   = column;
					end
					vumrc_pkg::SEL_PROTECT: begin
						written[j] = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (step) begin
			if (load) begin
				row_q[row_select] <= load_data;
			end else begin
				for (int j = 0; j < 4; j++) begin
					if (acc_en[j]) begin
						row_q[j] <= sum[j];
					end
				end
			end
		end
	end

endmodule

`default_nettype wire
